>>> rtl/lspe_pkg.sv
`default_nettype none
package lspe_pkg;

  // sensor array shape
  localparam int SENSOR_COUNT    = 5;
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int IDX_W           = $clog2(SENSOR_COUNT);

  // item and result field widths
  localparam int OP_W       = 2;
  localparam int ERR_W      = 9;
  localparam int STATUS_W   = 3;
  localparam int LIMIT_W    = 7;
  localparam int M_TDATA_W  = ((ERR_W + 7) / 8) * 8;

  // normalized scale and accumulator widths
  localparam int NORM_FULL  = 100;
  localparam int NORM_W     = 7;
  localparam int QUOT_W     = 8;
  localparam int WSUM_W     = 17;
  localparam int WSUM_MAG_W = 16;
  localparam int ASUM_W     = 9;

  // opcodes
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OP_W-1:0] OP_CALIB   = 2'd1;
  localparam logic [OP_W-1:0] OP_MEASURE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_MEASURED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BLACK    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WHITE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CAL      = 3'd4;

  // register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_WHITE = 1'b0;
  localparam logic REG_BLACK = 1'b1;
  localparam logic [LIMIT_W-1:0] WHITE_RST = 7'd20;
  localparam logic [LIMIT_W-1:0] BLACK_RST = 7'd80;

  typedef struct packed {
    logic [LIMIT_W-1:0] white_limit;
    logic [LIMIT_W-1:0] black_limit;
  } lspe_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic             capture;
    logic             calib;
    logic             load;
    logic             acc;
    logic             decide;
    logic             cdone;
    logic             out_load;
    logic [IDX_W-1:0] idx;
  } lspe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;
    logic div_done;
    logic need_div;
  } lspe_sts_t;

  // position weight of each sensor, left to right
  function automatic logic signed [ERR_W-1:0] lspe_weight(input logic [IDX_W-1:0] idx);
    logic signed [ERR_W-1:0] w;
    unique case (idx)
      3'd0:    w = -9'sd200;
      3'd1:    w = -9'sd100;
      3'd2:    w = 9'sd0;
      3'd3:    w = 9'sd100;
      3'd4:    w = 9'sd200;
      default: w = 9'sd0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/lspe_regs.sv
`default_nettype none
module lspe_regs import lspe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output lspe_cfg_t             cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes, one word per access
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.white_limit <= WHITE_RST;
      cfg.black_limit <= BLACK_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_WHITE: cfg.white_limit <= pwdata[LIMIT_W-1:0];
        REG_BLACK: cfg.black_limit <= pwdata[LIMIT_W-1:0];
        default:   ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[2])
      REG_WHITE: prdata = APB_DATA_W'(cfg.white_limit);
      REG_BLACK: prdata = APB_DATA_W'(cfg.black_limit);
      default:   prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/lspe_div.sv
`default_nettype none
module lspe_div import lspe_pkg::*; #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  dividend,
  input  logic [DEN_W-1:0]  divisor,
  output logic              done,
  output logic              sat,
  output logic [QUOT_W-1:0] quot
);

  localparam int TR_W    = DEN_W + QUOT_W;
  localparam int CMP_W   = (NUM_W > TR_W) ? NUM_W : TR_W;
  localparam int STEP_W  = $clog2(QUOT_W + 1);

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [NUM_W-1:0]    rem;
  logic [TR_W-1:0]     trial;
  logic                ge;

  assign ge = CMP_W'(rem) >= CMP_W'(trial);

  // control: step counts down from the overflow check to bit zero
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy) begin
        if ((step == STEP_W'(QUOT_W) && ge) || step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring divide, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= dividend;
      trial <= TR_W'(divisor) << QUOT_W;
      step  <= STEP_W'(QUOT_W);
      quot  <= '0;
      sat   <= 1'b0;
    end else if (busy) begin
      trial <= trial >> 1;
      if (step != '0) begin
        step <= step - 1'b1;
      end
      if (step == STEP_W'(QUOT_W)) begin
        sat <= ge;
      end else if (ge) begin
        rem                          <= rem - NUM_W'(trial);
        quot[step[STEP_W-2:0]]       <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/lspe_dp.sv
`default_nettype none
module lspe_dp import lspe_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lspe_cmd_t                           cmd,
  output lspe_sts_t                           sts,
  input  lspe_cfg_t                           cfg,
  input  logic [SENSOR_COUNT*SAMPLE_BITS-1:0] samples,
  input  logic [OP_W-1:0]                     opcode,
  output logic signed [ERR_W-1:0]             line_error,
  output logic [STATUS_W-1:0]                 status
);

  localparam int NUM_W = (SAMPLE_BITS + 7 > WSUM_MAG_W) ? SAMPLE_BITS + 7 : WSUM_MAG_W;
  localparam int DEN_W = (SAMPLE_BITS > ASUM_W) ? SAMPLE_BITS : ASUM_W;
  localparam int DIF_W = SAMPLE_BITS + 1;

  logic [SAMPLE_BITS-1:0]     smp [SENSOR_COUNT];
  logic [SAMPLE_BITS-1:0]     lo  [SENSOR_COUNT];
  logic [SAMPLE_BITS-1:0]     hi  [SENSOR_COUNT];
  logic [OP_W-1:0]            op;
  logic signed [ERR_W-1:0]    last_err;
  logic signed [WSUM_W-1:0]   wsum;
  logic [ASUM_W-1:0]          asum;
  logic                       black;
  logic                       white;
  logic                       skip;
  logic signed [ERR_W-1:0]    res_err;
  logic [STATUS_W-1:0]        res_status;

  logic [DIF_W-1:0]           diff_a;
  logic [DIF_W-1:0]           diff_d;
  logic [SAMPLE_BITS-1:0]     a_mag;
  logic [SAMPLE_BITS-1:0]     d_mag;
  logic                       skip_c;
  logic [NUM_W-1:0]           norm_num;
  logic [NORM_W-1:0]          norm;
  logic signed [WSUM_W-1:0]   norm_s;
  logic signed [WSUM_W-1:0]   wt_s;
  logic signed [WSUM_W-1:0]   prod;
  logic                       wsum_neg;
  logic [WSUM_W-1:0]          wsum_mag;
  logic [ERR_W-1:0]           q_ext;
  logic signed [ERR_W-1:0]    c_err;
  logic                       need_div;

  logic                       div_start;
  logic [NUM_W-1:0]           div_num;
  logic [DEN_W-1:0]           div_den;
  logic                       div_done;
  logic                       div_sat;
  logic [QUOT_W-1:0]          div_quot;

  // per-sensor setup: signed distances from the low bound
  assign diff_a   = {1'b0, smp[cmd.idx]} - {1'b0, lo[cmd.idx]};
  assign diff_d   = {1'b0, hi[cmd.idx]} - {1'b0, lo[cmd.idx]};
  assign a_mag    = diff_a[DIF_W-1] ? SAMPLE_BITS'(~diff_a + 1'b1) : diff_a[SAMPLE_BITS-1:0];
  assign d_mag    = diff_d[DIF_W-1] ? SAMPLE_BITS'(~diff_d + 1'b1) : diff_d[SAMPLE_BITS-1:0];
  // equal bounds, raw at the low bound, or a negative ratio all give zero
  assign skip_c   = (diff_d == '0) || (diff_a == '0) || (diff_a[DIF_W-1] != diff_d[DIF_W-1]);
  assign norm_num = NUM_W'(a_mag) * NUM_W'(NORM_FULL);

  // normalized value with clamp at full scale
  always_comb begin
    if (skip) begin
      norm = '0;
    end else if (div_sat || div_quot > QUOT_W'(NORM_FULL)) begin
      norm = NORM_W'(NORM_FULL);
    end else begin
      norm = div_quot[NORM_W-1:0];
    end
  end

  assign norm_s = WSUM_W'($signed({1'b0, norm}));
  assign wt_s   = WSUM_W'(lspe_weight(cmd.idx));
  assign prod   = norm_s * wt_s;

  // centroid sign and magnitude
  assign wsum_neg = wsum[WSUM_W-1];
  assign wsum_mag = wsum_neg ? (~wsum + 1'b1) : wsum;
  assign q_ext    = ERR_W'(div_quot);
  assign c_err    = wsum_neg ? $signed(~q_ext + 1'b1) : $signed(q_ext);
  assign need_div = !black && !white && (asum != '0);

  // shared divider: normalization per sensor, then the centroid
  assign div_start = (cmd.load && !skip_c) || (cmd.decide && need_div);
  assign div_num   = cmd.decide ? NUM_W'(wsum_mag) : norm_num;
  assign div_den   = cmd.decide ? DEN_W'(asum) : DEN_W'(d_mag);

  lspe_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .sat      (div_sat),
    .quot     (div_quot)
  );

  assign sts = '{skip: skip, div_done: div_done, need_div: need_div};

  // calibration bounds and last measured error
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SENSOR_COUNT; k++) begin
        lo[k] <= '1;
        hi[k] <= '0;
      end
      last_err <= '0;
    end else begin
      if (cmd.calib) begin
        for (int k = 0; k < SENSOR_COUNT; k++) begin
          if (op == OP_CLEAR) begin
            lo[k] <= '1;
            hi[k] <= '0;
          end else if (op == OP_CALIB) begin
            if (smp[k] < lo[k]) lo[k] <= smp[k];
            if (smp[k] > hi[k]) hi[k] <= smp[k];
          end
        end
      end
      if (cmd.cdone) begin
        last_err <= c_err;
      end
    end
  end

  // word capture, accumulation and result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int k = 0; k < SENSOR_COUNT; k++) begin
        smp[k] <= samples[k*SAMPLE_BITS +: SAMPLE_BITS];
      end
      op    <= opcode;
      wsum  <= '0;
      asum  <= '0;
      black <= 1'b1;
      white <= 1'b1;
    end
    if (cmd.calib) begin
      res_err    <= last_err;
      res_status <= ST_CAL;
    end
    if (cmd.load) begin
      skip <= skip_c;
    end
    if (cmd.acc) begin
      wsum  <= wsum + prod;
      asum  <= asum + ASUM_W'(norm);
      black <= black && (norm >= cfg.black_limit);
      white <= white && (norm <= cfg.white_limit);
    end
    if (cmd.decide) begin
      if (black) begin
        res_err    <= '0;
        res_status <= ST_BLACK;
      end else if (white) begin
        res_err    <= last_err;
        res_status <= ST_WHITE;
      end else if (asum == '0) begin
        res_err    <= last_err;
        res_status <= ST_ZERO;
      end
    end
    if (cmd.cdone) begin
      res_err    <= c_err;
      res_status <= ST_MEASURED;
    end
    if (cmd.out_load) begin
      line_error <= res_err;
      status     <= res_status;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lspe_ctrl.sv
`default_nettype none
module lspe_ctrl import lspe_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [OP_W-1:0] s_tuser,
  output logic            m_tvalid,
  input  logic            m_tready,
  output lspe_cmd_t       cmd,
  input  lspe_sts_t       sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CAL    = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_CDIV   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;

  assign s_tready = (state == S_IDLE);

  // sequencing: capture, calibrate or per-sensor normalize, decide, centroid, hand off
  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    cmd.idx    = idx;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          idx_next    = '0;
          state_next  = (s_tuser == OP_MEASURE) ? S_LOAD : S_CAL;
        end
      end
      S_CAL: begin
        cmd.calib  = 1'b1;
        state_next = S_FINISH;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.skip || sts.div_done) begin
          cmd.acc = 1'b1;
          if (idx == IDX_W'(SENSOR_COUNT - 1)) begin
            state_next = S_DECIDE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_LOAD;
          end
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = sts.need_div ? S_CDIV : S_FINISH;
      end
      S_CDIV: begin
        if (sts.div_done) begin
          cmd.cdone  = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      // output register valid
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/line_sensor_position_error_top.sv
// Line position error from five reflectance sensors. Each input word carries
// an opcode in s_tuser (clear calibration, widen calibration bounds, measure)
// and five raw samples in s_tdata; each word gives exactly one result word with
// the signed error (-200..200) in m_tdata and a status code in m_tuser. The
// block handles one word at a time. A measurement uses the single shared
// restoring divider that produces one quotient bit per cycle, once per sensor
// for normalization (skipped when the ratio would be zero or negative, cut
// short when it saturates) and once for the centroid division when one is
// needed. A finished result waits in the output register while the next
// word is taken in. The white and black thresholds are written through the
// APB port at byte addresses 0 and 4 and must only change while no word is in
// flight.
`default_nettype none
module line_sensor_position_error_top import lspe_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // sample_0 .. sample_4, SAMPLE_BITS each from bit 0 up, zero padded to bytes
  input  logic [((SENSOR_COUNT*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  // opcode
  input  logic [OP_W-1:0]       s_tuser,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // line_error in bits 8:0, zero padded
  output logic [M_TDATA_W-1:0]  m_tdata,
  // status
  output logic [STATUS_W-1:0]   m_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  lspe_cfg_t                cfg;
  lspe_cmd_t                cmd;
  lspe_sts_t                sts;
  logic signed [ERR_W-1:0]  line_error;

  lspe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lspe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  lspe_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg        (cfg),
    .samples    (s_tdata[SENSOR_COUNT*SAMPLE_BITS-1:0]),
    .opcode     (s_tuser),
    .line_error (line_error),
    .status     (m_tuser)
  );

  assign m_tdata = M_TDATA_W'($unsigned(line_error));

endmodule
`default_nettype wire

>>> rtl/lspe_checker.sv
`default_nettype none
module lspe_checker import lspe_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [STATUS_W-1:0]  m_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // one word in flight: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a word is in flight");

  // all black reports a centered line
  a_black_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_BLACK |-> m_tdata == '0)
    else $error("all black with nonzero error");

  // error stays within the weight span and the padding stays zero
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[ERR_W-1:0]) >= -9'sd200)
              && ($signed(m_tdata[ERR_W-1:0]) <= 9'sd200)
              && (m_tdata[M_TDATA_W-1:ERR_W] == '0))
    else $error("line error out of range");

  // status code within its defined set
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= ST_CAL)
    else $error("undefined status code");

endmodule

bind line_sensor_position_error_top lspe_checker u_lspe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
